>>> design/ilie_pkg.sv
// ilie_pkg: shared types, codes and defaults for the indexed list block.
// No dependencies; used by ilie_ctrl, ilie_dpath and the top level.

package ilie_pkg;

    // Built store depth by default, and the largest count a 6-bit field holds
    localparam int DEPTH_DEF   = 32;
    localparam int CNT_MAX     = 63;
    localparam int MAX_RESULTS = 32;

    localparam logic [5:0] CAP_RESET = 6'd32;

    // Operation codes carried in the kind field
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_ERASE  = 2'd1;
    localparam logic [1:0] KIND_DUMP   = 2'd2;
    localparam logic [1:0] KIND_NOP    = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_INDEX = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         position;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic [5:0]         count;
        logic               last;
    } out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_op;
        logic dump_step;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       list_empty;
        logic       dump_final;
        logic       slot_free;
    } stat_t;

endpackage

>>> design/ilie_ctrl.sv
// ilie_ctrl: sequencing state machine for the indexed list.
// Depends on ilie_pkg (state_t, cmd_t, stat_t, kind codes).

module ilie_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ilie_pkg::stat_t stat,
    output ilie_pkg::cmd_t  cmd
);

    ilie_pkg::state_t state_reg;
    ilie_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ilie_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ilie_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ilie_pkg::S_EXEC;
                end
            end
            ilie_pkg::S_EXEC:
            begin
                if (stat.kind == ilie_pkg::KIND_NOP)
                begin
                    state_next = ilie_pkg::S_IDLE;
                end
                else if (stat.kind == ilie_pkg::KIND_DUMP && !stat.list_empty)
                begin
                    state_next = ilie_pkg::S_DUMP;
                end
                else if (stat.slot_free)
                begin
                    state_next = ilie_pkg::S_IDLE;
                end
            end
            ilie_pkg::S_DUMP:
            begin
                if (stat.slot_free && stat.dump_final)
                begin
                    state_next = ilie_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ilie_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load_item = 1'b0;
        cmd.do_op     = 1'b0;
        cmd.dump_step = 1'b0;
        unique case (state_reg)
            ilie_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ilie_pkg::S_EXEC:
            begin
                if (stat.kind != ilie_pkg::KIND_NOP
                    && !(stat.kind == ilie_pkg::KIND_DUMP && !stat.list_empty))
                begin
                    cmd.do_op = stat.slot_free;
                end
            end
            ilie_pkg::S_DUMP:
            begin
                cmd.dump_step = stat.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // a dump never walks an empty list
    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ilie_pkg::S_DUMP |-> !stat.list_empty)
        else $error("dump sequencing on an empty list");

endmodule

>>> design/ilie_dpath.sv
// ilie_dpath: cell row, count, capacity register and result register.
// Depends on ilie_pkg (in_t, out_t, cmd_t, stat_t, codes).

module ilie_dpath
#(
    parameter int DEPTH = ilie_pkg::DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  ilie_pkg::in_t   in_data,
    input  logic            cfg_we,
    input  logic [5:0]      cfg_wdata,
    input  ilie_pkg::cmd_t  cmd,
    output ilie_pkg::stat_t stat,
    output logic            out_valid,
    input  logic            out_ready,
    output ilie_pkg::out_t  out_data
);

    // count is 6 bits wide, so no more than 63 cells can ever be in use
    localparam int         CELLS   = (DEPTH < ilie_pkg::CNT_MAX) ? DEPTH : ilie_pkg::CNT_MAX;
    localparam logic [5:0] CELLS_W = 6'(CELLS);
    localparam logic [5:0] MAXR_W  = 6'(ilie_pkg::MAX_RESULTS);

    logic signed [31:0] cells_reg  [CELLS];
    logic signed [31:0] cells_next [CELLS];
    logic signed [31:0] lower_nb   [CELLS];
    logic signed [31:0] upper_nb   [CELLS];

    logic [5:0]         used_reg, used_next;
    logic [5:0]         cap_reg;
    logic [5:0]         step_reg;
    logic [1:0]         kind_reg;
    logic [5:0]         pos_reg;
    logic signed [31:0] val_reg;
    logic               out_valid_reg, out_valid_next;
    ilie_pkg::out_t     out_reg, out_next;

    logic [5:0] cap_lim;
    logic [5:0] used_m1;
    logic [5:0] dump_n;
    logic       ins_ok, ers_ok, slot_free, load_out;

    // fixed neighbour taps for the shift network
    for (genvar g = 0; g < CELLS; g++)
    begin : g_nb
        if (g == 0)
        begin : g_lo0
            assign lower_nb[g] = cells_reg[g];
        end
        else
        begin : g_lo
            assign lower_nb[g] = cells_reg[g-1];
        end
        if (g == CELLS - 1)
        begin : g_hi0
            assign upper_nb[g] = cells_reg[g];
        end
        else
        begin : g_hi
            assign upper_nb[g] = cells_reg[g+1];
        end
    end

    assign cap_lim   = (cap_reg > CELLS_W) ? CELLS_W : cap_reg;
    assign used_m1   = used_reg - 6'd1;
    assign dump_n    = (used_reg > MAXR_W) ? MAXR_W : used_reg;
    assign ins_ok    = (used_reg < cap_lim) && (pos_reg <= used_reg);
    assign ers_ok    = (used_reg != 6'd0) && (pos_reg < used_reg);
    assign slot_free = !out_valid_reg || out_ready;

    assign stat.kind       = kind_reg;
    assign stat.list_empty = (used_reg == 6'd0);
    assign stat.dump_final = (step_reg == used_m1);
    assign stat.slot_free  = slot_free;

    // cell row: insert shifts up, erase shifts down, dump rotates left
    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (cmd.do_op && kind_reg == ilie_pkg::KIND_INSERT && ins_ok)
            begin
                if (6'(i) == pos_reg)
                begin
                    cells_next[i] = val_reg;
                end
                else if (6'(i) > pos_reg)
                begin
                    cells_next[i] = lower_nb[i];
                end
            end
            else if (cmd.do_op && kind_reg == ilie_pkg::KIND_ERASE && ers_ok)
            begin
                if (6'(i) >= pos_reg)
                begin
                    cells_next[i] = upper_nb[i];
                end
            end
            else if (cmd.dump_step)
            begin
                if (6'(i) == used_m1)
                begin
                    cells_next[i] = cells_reg[0];
                end
                else if (6'(i) < used_m1)
                begin
                    cells_next[i] = upper_nb[i];
                end
            end
        end
    end

    // result word and new count
    always_comb
    begin
        used_next = used_reg;
        out_next  = out_reg;
        load_out  = 1'b0;
        if (cmd.do_op)
        begin
            load_out         = 1'b1;
            out_next.element = '0;
            out_next.last    = 1'b1;
            case (kind_reg)
                ilie_pkg::KIND_INSERT:
                begin
                    if (used_reg >= cap_lim)
                    begin
                        out_next.status = ilie_pkg::STAT_FULL;
                    end
                    else if (pos_reg > used_reg)
                    begin
                        out_next.status = ilie_pkg::STAT_INDEX;
                    end
                    else
                    begin
                        out_next.status = ilie_pkg::STAT_OK;
                        used_next       = used_reg + 6'd1;
                    end
                end
                ilie_pkg::KIND_ERASE:
                begin
                    if (used_reg == 6'd0)
                    begin
                        out_next.status = ilie_pkg::STAT_EMPTY;
                    end
                    else if (pos_reg >= used_reg)
                    begin
                        out_next.status = ilie_pkg::STAT_INDEX;
                    end
                    else
                    begin
                        out_next.status = ilie_pkg::STAT_OK;
                        used_next       = used_m1;
                    end
                end
                default:
                begin
                    // only an empty dump gets here
                    out_next.status = ilie_pkg::STAT_EMPTY;
                end
            endcase
            out_next.count = used_next;
        end
        else if (cmd.dump_step)
        begin
            // past the result limit the row still rotates home, silently
            load_out         = (step_reg < MAXR_W);
            out_next.status  = ilie_pkg::STAT_OK;
            out_next.element = cells_reg[0];
            out_next.count   = used_reg;
            out_next.last    = (step_reg == dump_n - 6'd1);
        end
        out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= 6'd0;
            cap_reg       <= ilie_pkg::CAP_RESET;
            step_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.load_item)
            begin
                step_reg <= 6'd0;
            end
            else if (cmd.dump_step)
            begin
                step_reg <= step_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
        if (cmd.load_item)
        begin
            kind_reg <= in_data.kind;
            pos_reg  <= in_data.position;
            val_reg  <= in_data.value;
        end
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CELLS_W)
        else $error("count beyond built store");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_op || cmd.dump_step) |-> slot_free)
        else $error("result register overwritten while held");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_op && kind_reg == ilie_pkg::KIND_INSERT && ins_ok)
        |=> used_reg == 6'($past(used_reg) + 6'd1))
        else $error("insert did not advance the count");

endmodule

>>> design/indexed_list_insert_erase_top.sv
// indexed_list_insert_erase_top: ordered list with insert/erase at an index.
// Depends on ilie_pkg, ilie_ctrl and ilie_dpath.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+------------------------------
//   in      | in        | in_valid / in_ready  | ilie_pkg::in_t  (kind, position, value)
//   out     | out       | out_valid / out_ready| ilie_pkg::out_t (status, element, count, last)
//   cfg     | in        | cfg_we               | cfg_wdata = capacity
//
// Sequencing: one word at a time. Insert, erase and empty dump are accepted,
//   then executed in one step that writes the result (a successful insert or erase
//   also shifts the cell row once); a dump rotates the cell row once per entry.
// The result register parts the two sides: the next word is taken while a
//   result still waits on out_ready.
// Stalls: a full result register holds the operation in place until it drains.
// Reset: count 0, capacity 32, no result pending; the cell row is not cleared
//   and needs no clearing pass.

module indexed_list_insert_erase_top
#(
    parameter int DEPTH = ilie_pkg::DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ilie_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ilie_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [5:0]     cfg_wdata
);

    ilie_pkg::cmd_t  cmd;
    ilie_pkg::stat_t stat;

    // controller: accept, execute, dump walk
    ilie_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: cell row, count, capacity and the result register
    ilie_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
